@@ hdl/vrdt_pkg.sv @@
// Shared constants, request codes and status codes of the word vector engine.
package vrdt_pkg;

	localparam int VRDT_DEPTH     = 64;
	localparam int VRDT_WORD_BITS = 32;

	localparam int REQ_BITS  = 3;
	localparam int AMT_BITS  = 16;
	localparam int POS_BITS  = 6;
	localparam int DATA_BITS = 32;
	localparam int STAT_BITS = 3;
	localparam int LEN_BITS  = 7;

	localparam logic [REQ_BITS-1:0] REQ_APPEND = 3'd0;
	localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 3'd1;
	localparam logic [REQ_BITS-1:0] REQ_ROTR   = 3'd2;
	localparam logic [REQ_BITS-1:0] REQ_ROTL   = 3'd3;
	localparam logic [REQ_BITS-1:0] REQ_DELETE = 3'd4;
	localparam logic [REQ_BITS-1:0] REQ_SEARCH = 3'd5;

	localparam logic [STAT_BITS-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_BITS-1:0] STAT_RANGE     = 3'd1;
	localparam logic [STAT_BITS-1:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [STAT_BITS-1:0] STAT_EMPTY     = 3'd3;
	localparam logic [STAT_BITS-1:0] STAT_FULL      = 3'd4;

endpackage

@@ hdl/vrdt_ram.sv @@
// Simple dual-port word memory: one write port, one registered read port.
module vrdt_ram #(
	parameter int AW = 6,
	parameter int WW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [WW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WW-1:0] rdata
);

	logic [WW-1:0] mem_q [(1 << AW)];
	logic [WW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/vrdt_mod.sv @@
// Bit-serial remainder unit: dividend modulo divisor, one dividend bit per cycle.
module vrdt_mod import vrdt_pkg::*; #(
	parameter int CW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [AMT_BITS-1:0] dividend,
	input  logic [CW-1:0]       divisor,
	output logic                done,
	output logic [CW-1:0]       rem
);

	localparam int IW = $clog2(AMT_BITS + 1);

	logic [AMT_BITS-1:0] a_q;
	logic [CW-1:0]       d_q;
	logic [CW-1:0]       rem_q;
	logic [IW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [CW:0]         trial;
	logic [CW:0]         nxt;

	// shift in the next dividend bit, subtract the divisor when it fits
	assign trial = {rem_q, a_q[AMT_BITS-1]};
	assign nxt   = (trial >= {1'b0, d_q}) ? (trial - {1'b0, d_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			d_q    <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= dividend;
				d_q    <= divisor;
				rem_q  <= '0;
				cnt_q  <= IW'(AMT_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				a_q   <= {a_q[AMT_BITS-2:0], 1'b0};
				rem_q <= nxt[CW-1:0];
				cnt_q <= cnt_q - IW'(1);
				if (cnt_q == IW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ hdl/vector_rotate_delete_transpose_engine.sv @@
// Ordered word vector engine: append, clear, rotate, delete and transposition search.
//
// The block holds up to DEPTH words of WORD_BITS bits in order, plus a live count,
// and answers every request beat with exactly one result beat. It works on one
// request at a time; in_ready is high only while the sequencer is idle, but a
// finished result sits in its own output register, so the next request can be
// taken while that result still waits for out_ready. Append, clear, unused codes
// and every request that fails its checks go straight to the result state and
// load the result register once it is free. Rotate left one (a single word stays
// put): every word is read once through the single read port of the element
// memory and written to a scratch memory at its rotated place, then copied back.
// Rotate right first reduces the amount modulo the count in a bit-serial remainder
// unit, one amount bit per cycle, then does the same two copy passes; an amount
// that reduces to zero skips them. Delete walks from the position to the end, one
// word per cycle, closing the gap. Search reads one word per cycle from the front
// until the first match, swaps it with its predecessor in an extra state and
// returns the new position. The worst case is set by the one-word-per-cycle memory
// port and the remainder unit. The memories need no clearing after reset: only
// words below the count are ever read, and those are always written first.
// word_out is zero for all but a successful delete, found_index is zero for all
// but a successful search, and length always gives the count after the request.
module vector_rotate_delete_transpose_engine import vrdt_pkg::*; #(
	parameter int DEPTH     = VRDT_DEPTH,
	parameter int WORD_BITS = VRDT_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [REQ_BITS-1:0]  req_type,
	input  logic [AMT_BITS-1:0]  amount,
	input  logic [POS_BITS-1:0]  position,
	input  logic [DATA_BITS-1:0] word_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_BITS-1:0] word_out,
	output logic [POS_BITS-1:0]  found_index,
	output logic [STAT_BITS-1:0] status,
	output logic [LEN_BITS-1:0]  length
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_ROTA = 4'd2;
	localparam logic [3:0] S_ROTB = 4'd3;
	localparam logic [3:0] S_DEL  = 4'd4;
	localparam logic [3:0] S_SRCH = 4'd5;
	localparam logic [3:0] S_SWAP = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;

	logic [3:0]           state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        i_q;      // read issue index
	logic [AW-1:0]        j_q;      // rotated destination index
	logic [AW-1:0]        pos_q;
	logic [AW-1:0]        hit_q;
	logic [WORD_BITS-1:0] key_q;
	logic [WORD_BITS-1:0] prev_q;
	logic                 v_s1;     // a read returns this cycle
	logic [AW-1:0]        idx_s1;   // index of the word being returned
	logic [AW-1:0]        dst_s1;   // its destination in the scratch memory

	logic [WORD_BITS-1:0] res_word_q;
	logic [AW-1:0]        res_found_q;
	logic [STAT_BITS-1:0] res_status_q;

	logic                 out_valid_q;
	logic [DATA_BITS-1:0] word_out_q;
	logic [POS_BITS-1:0]  found_index_q;
	logic [STAT_BITS-1:0] status_q;
	logic [LEN_BITS-1:0]  length_q;

	logic                 in_fire;
	logic                 issue;
	logic                 match;
	logic                 out_load;
	logic [AW-1:0]        j_next;

	logic                 elem_we;
	logic [AW-1:0]        elem_waddr;
	logic [WORD_BITS-1:0] elem_wdata;
	logic [WORD_BITS-1:0] elem_rdata;
	logic                 scr_we;
	logic [WORD_BITS-1:0] scr_rdata;

	logic                 mod_start;
	logic                 mod_done;
	logic [CW-1:0]        mod_rem;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign issue    = (i_q < count_q);
	assign match    = v_s1 && (elem_rdata == key_q);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign j_next   = (CW'(j_q) == count_q - CW'(1)) ? '0 : (j_q + AW'(1));

	assign mod_start = in_fire && (req_type == REQ_ROTR) && (count_q != '0);

	// element memory write port: append, copy back, gap closing, search swap
	always_comb begin
		elem_we    = 1'b0;
		elem_waddr = '0;
		elem_wdata = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire && (req_type == REQ_APPEND) && (count_q != CW'(DEPTH))) begin
					elem_we    = 1'b1;
					elem_waddr = AW'(count_q);
					elem_wdata = WORD_BITS'(word_in);
				end
			end
			S_ROTB: begin
				elem_we    = v_s1;
				elem_waddr = idx_s1;
				elem_wdata = scr_rdata;
			end
			S_DEL: begin
				elem_we    = v_s1 && (idx_s1 != pos_q);
				elem_waddr = idx_s1 - AW'(1);
				elem_wdata = elem_rdata;
			end
			S_SRCH: begin
				// move the key one place forward; its old place gets the predecessor next
				elem_we    = match && (idx_s1 != '0);
				elem_waddr = idx_s1 - AW'(1);
				elem_wdata = key_q;
			end
			S_SWAP: begin
				elem_we    = 1'b1;
				elem_waddr = hit_q;
				elem_wdata = prev_q;
			end
			default: begin
				elem_we = 1'b0;
			end
		endcase
	end

	assign scr_we = (state_q == S_ROTA) && v_s1;

	vrdt_ram #(
		.AW (AW),
		.WW (WORD_BITS)
	) u_elem (
		.clk   (clk),
		.we    (elem_we),
		.waddr (elem_waddr),
		.wdata (elem_wdata),
		.raddr (i_q[AW-1:0]),
		.rdata (elem_rdata)
	);

	vrdt_ram #(
		.AW (AW),
		.WW (WORD_BITS)
	) u_scratch (
		.clk   (clk),
		.we    (scr_we),
		.waddr (dst_s1),
		.wdata (elem_rdata),
		.raddr (i_q[AW-1:0]),
		.rdata (scr_rdata)
	);

	vrdt_mod #(
		.CW (CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (amount),
		.divisor  (count_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			pos_q        <= '0;
			hit_q        <= '0;
			key_q        <= '0;
			prev_q       <= '0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			dst_s1       <= '0;
			res_word_q   <= '0;
			res_found_q  <= '0;
			res_status_q <= STAT_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					v_s1 <= 1'b0;
					if (in_fire) begin
						key_q        <= WORD_BITS'(word_in);
						res_word_q   <= '0;
						res_found_q  <= '0;
						res_status_q <= STAT_OK;
						i_q          <= '0;
						state_q      <= S_FIN;
						case (req_type)
							REQ_APPEND: begin
								if (count_q == CW'(DEPTH)) begin
									res_status_q <= STAT_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							REQ_CLEAR: begin
								count_q <= '0;
							end
							REQ_ROTR: begin
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									state_q <= S_DIV;
								end
							end
							REQ_ROTL: begin
								// left by one is right by count - 1; a single word stays put
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
								end else if (count_q != CW'(1)) begin
									j_q     <= AW'(count_q - CW'(1));
									state_q <= S_ROTA;
								end
							end
							REQ_DELETE: begin
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
								end else if (PW'(position) >= PW'(count_q)) begin
									res_status_q <= STAT_RANGE;
								end else begin
									i_q     <= CW'(position);
									pos_q   <= AW'(position);
									state_q <= S_DEL;
								end
							end
							REQ_SEARCH: begin
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									state_q <= S_SRCH;
								end
							end
							default: begin
								res_status_q <= STAT_OK;
							end
						endcase
					end
				end
				S_DIV: begin
					if (mod_done) begin
						if (mod_rem == '0) begin
							state_q <= S_FIN;
						end else begin
							j_q     <= AW'(mod_rem);
							state_q <= S_ROTA;
						end
					end
				end
				S_ROTA: begin
					// scatter every word to its rotated place in scratch
					v_s1   <= issue;
					dst_s1 <= j_q;
					if (issue) begin
						i_q <= i_q + CW'(1);
						j_q <= j_next;
					end else if (!v_s1) begin
						i_q     <= '0;
						state_q <= S_ROTB;
					end
				end
				S_ROTB: begin
					// copy scratch back in order
					v_s1   <= issue;
					idx_s1 <= i_q[AW-1:0];
					if (issue) begin
						i_q <= i_q + CW'(1);
					end else if (!v_s1) begin
						state_q <= S_FIN;
					end
				end
				S_DEL: begin
					v_s1   <= issue;
					idx_s1 <= i_q[AW-1:0];
					if (v_s1 && (idx_s1 == pos_q)) begin
						res_word_q <= elem_rdata;
					end
					if (issue) begin
						i_q <= i_q + CW'(1);
					end else if (!v_s1) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_SRCH: begin
					if (match) begin
						// drop the read in flight, first match wins
						v_s1         <= 1'b0;
						res_status_q <= STAT_OK;
						if (idx_s1 == '0) begin
							res_found_q <= '0;
							state_q     <= S_FIN;
						end else begin
							res_found_q <= idx_s1 - AW'(1);
							hit_q       <= idx_s1;
							state_q     <= S_SWAP;
						end
					end else begin
						if (v_s1) begin
							prev_q <= elem_rdata;
						end
						v_s1   <= issue;
						idx_s1 <= i_q[AW-1:0];
						if (issue) begin
							i_q <= i_q + CW'(1);
						end else if (!v_s1) begin
							res_status_q <= STAT_NOT_FOUND;
							state_q      <= S_FIN;
						end
					end
				end
				S_SWAP: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register: hold until taken, load when free or being emptied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			word_out_q    <= '0;
			found_index_q <= '0;
			status_q      <= STAT_OK;
			length_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q   <= 1'b1;
				word_out_q    <= DATA_BITS'(res_word_q);
				found_index_q <= POS_BITS'(res_found_q);
				status_q      <= res_status_q;
				length_q      <= LEN_BITS'(count_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign word_out    = word_out_q;
	assign found_index = found_index_q;
	assign status      = status_q;
	assign length      = length_q;

endmodule

@@ hdl/vrdt_checker.sv @@
// Port-level checker for the word vector engine, bound to the top level.
module vrdt_checker import vrdt_pkg::*; #(
	parameter int DEPTH = VRDT_DEPTH
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [DATA_BITS-1:0] word_out,
	input logic [POS_BITS-1:0]  found_index,
	input logic [STAT_BITS-1:0] status,
	input logic [LEN_BITS-1:0]  length
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_out) && $stable(status)
			&& $stable(found_index) && $stable(length))
		else $error("result beat changed while stalled");

	// a failed request returns no word and no position
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> (word_out == '0) && (found_index == '0))
		else $error("failed request carries data");

	// full only at the depth, empty only at zero
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_FULL) |-> (length == LEN_BITS'(DEPTH)))
		else $error("full status with count below depth");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_EMPTY) |-> (length == '0))
		else $error("empty status with a nonzero count");

	// one request at a time: busy after every accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one still in work");

endmodule

bind vector_rotate_delete_transpose_engine vrdt_checker #(.DEPTH(DEPTH)) u_vrdt_checker (.*);

@@ verif/tb.sv @@
// Testbench for the word vector engine: shadow vector, result scoreboard and request traffic.
module tb;
	import vrdt_pkg::*;

	// Request codes the block treats as no-ops
	localparam logic [REQ_BITS-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_BITS-1:0] REQ_SPARE_HI = 3'd7;

	localparam int RANDOM_BEATS  = 1050;
	localparam int MAX_GAP       = 14;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 200;
	localparam int STALL_LIMIT   = 4000;
	localparam int MAX_PRINTED   = 100;

	typedef struct packed {
		logic [REQ_BITS-1:0]  kind;
		logic [AMT_BITS-1:0]  amount;
		logic [POS_BITS-1:0]  position;
		logic [DATA_BITS-1:0] word;
	} request_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] word;
		logic [POS_BITS-1:0]  found;
		logic [STAT_BITS-1:0] status;
		logic [LEN_BITS-1:0]  length;
	} outcome_t;

	// Shadow copy of the vector; works out each request's outcome and queues it
	class vector_shadow;
		logic [DATA_BITS-1:0] words [VRDT_DEPTH];
		int unsigned count;
		outcome_t pending [$];

		function void note_request(request_t r);
			logic [DATA_BITS-1:0] spill [VRDT_DEPTH];
			logic [DATA_BITS-1:0] held;
			outcome_t o;
			int unsigned k;
			o = '0;
			o.status = STAT_OK;
			case (r.kind)
			REQ_APPEND: begin
				if (count >= VRDT_DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					words[count] = r.word;
					count++;
				end
			end
			REQ_CLEAR: begin
				count = 0;
			end
			REQ_ROTR, REQ_ROTL: begin
				if (count == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					// rotating left by one is rotating right by count - 1
					k = (r.kind == REQ_ROTL) ? count - 1 : r.amount % count;
					for (int i = 0; i < count; i++) spill[(i + k) % count] = words[i];
					for (int i = 0; i < count; i++) words[i] = spill[i];
				end
			end
			REQ_DELETE: begin
				if (count == 0) begin
					o.status = STAT_EMPTY;
				end else if (r.position >= count) begin
					o.status = STAT_RANGE;
				end else begin
					o.word = words[r.position];
					for (int i = r.position + 1; i < count; i++) words[i - 1] = words[i];
					count--;
				end
			end
			REQ_SEARCH: begin
				if (count == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					o.status = STAT_NOT_FOUND;
					for (int i = 0; i < count; i++) begin
						if (words[i] == r.word) begin
							// first match moves one place towards the front
							if (i != 0) begin
								held = words[i - 1];
								words[i - 1] = words[i];
								words[i] = held;
								o.found = POS_BITS'(i - 1);
							end
							o.status = STAT_OK;
							break;
						end
					end
				end
			end
			default: begin
			end
			endcase
			o.length = LEN_BITS'(count);
			pending = {pending, o};
		endfunction

		function string check_outcome(outcome_t got);
			outcome_t want;
			string diff;
			if (pending.size() == 0)
				return $sformatf("result beat with nothing expected: %h %0d %0d %0d",
					got.word, got.found, got.status, got.length);
			want = pending.pop_front();
			diff = "";
			if (got.word !== want.word)
				diff = {diff, $sformatf(" word_out %h/%h", got.word, want.word)};
			if (got.found !== want.found)
				diff = {diff, $sformatf(" found_index %0d/%0d", got.found, want.found)};
			if (got.status !== want.status)
				diff = {diff, $sformatf(" status %0d/%0d", got.status, want.status)};
			if (got.length !== want.length)
				diff = {diff, $sformatf(" length %0d/%0d", got.length, want.length)};
			if (diff != "") diff = {"result beat differs (got/expected):", diff};
			return diff;
		endfunction

		function logic [DATA_BITS-1:0] stored_word();
			return words[$urandom_range(0, count - 1)];
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [REQ_BITS-1:0]  req_type = '0;
	logic [AMT_BITS-1:0]  amount = '0;
	logic [POS_BITS-1:0]  position = '0;
	logic [DATA_BITS-1:0] word_in = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DATA_BITS-1:0] word_out;
	logic [POS_BITS-1:0]  found_index;
	logic [STAT_BITS-1:0] status;
	logic [LEN_BITS-1:0]  length;

	vector_shadow shadow = new();
	int errors = 0;
	int idle_cycles = 0;
	int random_sent = 0;
	bit send_rush = 1'b0;
	bit take_rush = 1'b0;
	bit hold_pending = 1'b0;
	logic [DATA_BITS-1:0] word_pool [8];

	vector_rotate_delete_transpose_engine DUT (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .amount, .position, .word_in,
		.out_valid, .out_ready, .word_out, .found_index, .status, .length
	);

	always #2 clk = ~clk;

	task automatic report(string what);
		errors++;
		if (errors <= MAX_PRINTED) $display("[%0t] %s", $time, what);
	endtask

	// Offer one request beat after a random gap and note it once taken
	task automatic send_request(request_t r);
		int gap;
		gap = send_rush ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type <= r.kind;
		amount   <= r.amount;
		position <= r.position;
		word_in  <= r.word;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		shadow.note_request(r);
		if ($urandom_range(0, 39) == 0) send_rush = !send_rush;
	endtask

	// Drop valid and hold until every outstanding result has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (shadow.pending.size() != 0) @(posedge clk);
	endtask

	function automatic request_t pick_request();
		request_t r;
		int unsigned n;
		int unsigned roll;
		n = shadow.count;
		r.amount = AMT_BITS'($urandom);
		r.position = POS_BITS'($urandom);
		r.word = $urandom;
		roll = $urandom_range(0, 99);
		if (roll < ((n < 6) ? 50 : 25)) begin
			r.kind = REQ_APPEND;
			// reuse a few values so searches meet duplicates
			if ($urandom_range(0, 1)) r.word = word_pool[$urandom_range(0, 7)];
			return r;
		end
		roll = $urandom_range(0, 99);
		if (roll < 28) begin
			r.kind = REQ_SEARCH;
			if (n > 0 && $urandom_range(0, 4) != 0) r.word = shadow.stored_word();
			else if ($urandom_range(0, 1)) r.word = word_pool[$urandom_range(0, 7)];
		end else if (roll < 46) begin
			r.kind = REQ_ROTR;
			case ($urandom_range(0, 3))
			2: r.amount = AMT_BITS'($urandom_range(0, n));
			3: r.amount = AMT_BITS'(n * $urandom_range(0, 3));
			default: begin
			end
			endcase
		end else if (roll < 62) begin
			r.kind = REQ_ROTL;
		end else if (roll < 88) begin
			r.kind = REQ_DELETE;
			if (n > 0 && $urandom_range(0, 5) != 0) r.position = POS_BITS'($urandom_range(0, n - 1));
		end else if (roll < 93) begin
			r.kind = REQ_CLEAR;
		end else begin
			r.kind = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
		end
		return r;
	endfunction

	// Append until the vector is full, then push two more into the full vector
	task automatic fill_vector();
		request_t r;
		int extra;
		extra = 2;
		while (shadow.count < VRDT_DEPTH || extra > 0) begin
			if (shadow.count >= VRDT_DEPTH) extra--;
			r = pick_request();
			r.kind = REQ_APPEND;
			send_request(r);
			random_sent++;
		end
	endtask

	// Check every result beat taken
	always @(posedge clk) begin
		string fault;
		if (arst_n && out_valid && out_ready) begin
			fault = shadow.check_outcome({word_out, found_index, status, length});
			if (fault != "") report(fault);
		end
	end

	// Take result beats after random stalls; once, hold off long enough to back up the input
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_pending) begin
				stall = LONG_HOLD;
				hold_pending = 1'b0;
			end else begin
				stall = take_rush ? 0 : $urandom_range(0, MAX_GAP);
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if ($urandom_range(0, 39) == 0) take_rush = !take_rush;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		bit hold_done;
		bit pause_done;
		int next_fill;
		hold_done = 1'b0;
		pause_done = 1'b0;
		next_fill = 150;
		word_pool[0] = '0;
		word_pool[1] = '1;
		for (int i = 2; i < 8; i++) word_pool[i] = $urandom;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty vector: every request that needs a word fails
		send_request(request_t'{REQ_SEARCH, 16'd0, 6'd0, 32'h0});
		send_request(request_t'{REQ_ROTR, 16'd5, 6'd0, 32'h0});
		send_request(request_t'{REQ_ROTL, 16'd0, 6'd0, 32'h0});
		send_request(request_t'{REQ_DELETE, 16'd0, 6'd0, 32'h0});
		send_request(request_t'{REQ_APPEND, 16'd0, 6'd0, 32'h0000_0000});
		send_request(request_t'{REQ_APPEND, 16'd0, 6'd0, 32'hFFFF_FFFF});
		send_request(request_t'{REQ_APPEND, 16'd0, 6'd0, 32'h5A5A_A5A5});
		send_request(request_t'{REQ_APPEND, 16'd0, 6'd0, 32'hFFFF_FFFF});
		// first match swaps to the front, then matches at the front without a swap
		send_request(request_t'{REQ_SEARCH, 16'd0, 6'd0, 32'hFFFF_FFFF});
		send_request(request_t'{REQ_SEARCH, 16'd0, 6'd0, 32'hFFFF_FFFF});
		send_request(request_t'{REQ_SEARCH, 16'd0, 6'd0, 32'h1234_5678});
		send_request(request_t'{REQ_DELETE, 16'd0, 6'd63, 32'h0});
		send_request(request_t'{REQ_DELETE, 16'd0, 6'd4, 32'h0});
		send_request(request_t'{REQ_ROTR, 16'hFFFF, 6'd0, 32'h0});
		send_request(request_t'{REQ_ROTR, 16'd0, 6'd0, 32'h0});
		send_request(request_t'{REQ_ROTL, 16'd0, 6'd0, 32'h0});
		send_request(request_t'{REQ_SEARCH, 16'd0, 6'd0, 32'h5A5A_A5A5});
		send_request(request_t'{REQ_DELETE, 16'd0, 6'd3, 32'h0});
		send_request(request_t'{REQ_DELETE, 16'd0, 6'd0, 32'h0});
		send_request(request_t'{REQ_SPARE_LO, 16'hFFFF, 6'd63, 32'hFFFF_FFFF});
		send_request(request_t'{REQ_SPARE_HI, 16'hFFFF, 6'd63, 32'hFFFF_FFFF});
		send_request(request_t'{REQ_APPEND, 16'd0, 6'd0, 32'h8000_0001});
		send_request(request_t'{REQ_CLEAR, 16'd0, 6'd0, 32'h0});
		send_request(request_t'{REQ_DELETE, 16'd0, 6'd0, 32'h0});
		send_request(request_t'{REQ_APPEND, 16'd0, 6'd0, 32'hDEAD_BEEF});
		drain_results();

		while (random_sent < RANDOM_BEATS) begin
			if (!hold_done && random_sent >= 400) begin
				hold_pending = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && random_sent >= 700) begin
				drain_results();
				pause_done = 1'b1;
			end
			if (random_sent >= next_fill) begin
				fill_vector();
				next_fill += 350;
			end
			send_request(pick_request());
			random_sent++;
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
